### design/sitb_pkg.sv
// Package for the signed integer to digit-register writer.
// Holds widths, register addresses, config indexes and the cell control type.
// No dependencies.
package sitb_pkg;

    localparam int NUM_DIGITS_DEF = 8;
    localparam int BCD_CELLS      = 10;
    localparam int MAG_W          = 32;
    localparam int CNT_W          = 5;
    localparam int DCNT_W         = 4;

    localparam logic [3:0] DECODE_MODE_ADDR = 4'd9;
    localparam logic [7:0] DECODE_ALL       = 8'hFF;

    localparam logic CFG_RESTORE_DECODE = 1'b0;
    localparam logic CFG_MINUS_CODE     = 1'b1;

    localparam logic [7:0] RESTORE_DECODE_RST = 8'd0;
    localparam logic [7:0] MINUS_CODE_RST     = 8'd10;

    typedef struct packed {
        logic clear;
        logic conv;
        logic move;
    } cell_ctrl_t;

endpackage

### design/sitb_ifs.sv
// Channel interfaces: number input and register-write output.
// Valid/ready handshake; depends on nothing.
interface sitb_num_if;
    logic        valid;
    logic        ready;
    logic [31:0] number_value;
    logic [3:0]  start_position;

    modport source (output valid, number_value, start_position, input ready);
    modport sink   (input valid, number_value, start_position, output ready);
endinterface

interface sitb_wr_if;
    logic       valid;
    logic       ready;
    logic [3:0] register_address;
    logic [7:0] register_data;
    logic [3:0] remaining_position;
    logic       last_write;

    modport source (output valid, register_address, register_data, remaining_position,
                    last_write, input ready);
    modport sink   (input valid, register_address, register_data, remaining_position,
                    last_write, output ready);
endinterface

### design/sitb_bcd_cell.sv
// One BCD digit cell of the double-dabble chain.
// Converts one bit per cycle, or moves digits up the chain for output. Uses sitb_pkg.
module sitb_bcd_cell
    import sitb_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       carry_in,
    input  logic [3:0] digit_in,
    output logic       carry_out,
    output logic [3:0] digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    assign adj       = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry_out = adj[3];
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = 4'd0;
        end
        else if (ctrl.conv)
        begin
            digit_next = {adj[2:0], carry_in};
        end
        else if (ctrl.move)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

### design/signed_int_to_digit_writes_top.sv
// Top level: signed 32-bit number to seven-segment register writes.
// Uses sitb_pkg, sitb_ifs and a chain of sitb_bcd_cell.
//
// Channel  Dir  Payload
// num      in   number_value[31:0] signed, start_position[3:0]
// wr       out  register_address[3:0], register_data[7:0], remaining_position[3:0], last_write
// cfg      in   cfg_we, cfg_index[0], cfg_wdata[7:0]
//
// One number at a time: an accept step, conversion one bit per cycle through the
// ten-cell digit chain, a skip over leading zeros, then the writes (2 to 10 writes),
// ending with the decode restore after the last digit; a negative number always
// passes through the sign state.
// A stall on wr holds the output register and freezes the write states; conversion and skipping go on.
// Reset is asynchronous, active low; config resets to decode 0, minus code 10.
module signed_int_to_digit_writes_top
    import sitb_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    sitb_num_if.sink        num,
    sitb_wr_if.source       wr,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [7:0]      cfg_wdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_SKIP  = 3'd2;
    localparam logic [2:0] ST_HEAD  = 3'd3;
    localparam logic [2:0] ST_SIGN  = 3'd4;
    localparam logic [2:0] ST_DIGIT = 3'd5;
    localparam logic [2:0] ST_TAIL  = 3'd6;

    localparam logic [3:0] POS_MAX = 4'(NUM_DIGITS);

    logic [2:0]        state_reg, state_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic [3:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [7:0]        restore_reg, minus_reg;

    logic       out_valid_reg, out_valid_next;
    logic [3:0] out_addr_reg, out_addr_next;
    logic [7:0] out_data_reg, out_data_next;
    logic [3:0] out_rem_reg, out_rem_next;
    logic       out_last_reg, out_last_next;

    cell_ctrl_t ctrl;
    logic [BCD_CELLS-1:0] carry;
    logic [3:0]           digits [BCD_CELLS];
    logic [3:0]           top_digit;
    logic                 load_ok;
    logic                 in_xfer;
    logic [31:0]          raw;

    assign top_digit = digits[BCD_CELLS-1];
    assign load_ok   = !out_valid_reg || wr.ready;
    assign num.ready = (state_reg == ST_IDLE);
    assign in_xfer   = num.valid && num.ready;
    assign raw       = num.number_value;

    genvar gi;
    generate
        for (gi = 0; gi < BCD_CELLS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                sitb_bcd_cell u_cell (
                    .clk       (clk),
                    .ctrl      (ctrl),
                    .carry_in  (mag_reg[MAG_W-1]),
                    .digit_in  (4'd0),
                    .carry_out (carry[gi]),
                    .digit     (digits[gi])
                );
            end
            else
            begin : g_rest
                sitb_bcd_cell u_cell (
                    .clk       (clk),
                    .ctrl      (ctrl),
                    .carry_in  (carry[gi-1]),
                    .digit_in  (digits[gi-1]),
                    .carry_out (carry[gi]),
                    .digit     (digits[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg && !wr.ready;
        out_addr_next  = out_addr_reg;
        out_data_next  = out_data_reg;
        out_rem_next   = out_rem_reg;
        out_last_next  = out_last_reg;
        ctrl           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    neg_next   = raw[31];
                    mag_next   = raw[31] ? (32'd0 - raw) : raw;
                    pos_next   = (num.start_position > POS_MAX) ? POS_MAX
                                                                : num.start_position;
                    cnt_next   = '0;
                    dcnt_next  = DCNT_W'(BCD_CELLS);
                    ctrl.clear = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctrl.conv = 1'b1;
                mag_next  = {mag_reg[MAG_W-2:0], 1'b0};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (top_digit == 4'd0 && dcnt_reg > DCNT_W'(1))
                begin
                    ctrl.move = 1'b1;
                    dcnt_next = dcnt_reg - DCNT_W'(1);
                end
                else
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = DECODE_MODE_ADDR;
                    out_data_next  = DECODE_ALL;
                    out_rem_next   = 4'd0;
                    out_last_next  = 1'b0;
                    state_next     = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (pos_reg == 4'd0)
                begin
                    state_next = ST_DIGIT;
                end
                else if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = pos_reg;
                    out_data_next  = minus_reg;
                    out_rem_next   = 4'd0;
                    out_last_next  = 1'b0;
                    pos_next       = pos_reg - 4'd1;
                    state_next     = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (pos_reg == 4'd0 || dcnt_reg == '0)
                begin
                    state_next = ST_TAIL;
                end
                else if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = pos_reg;
                    out_data_next  = {4'd0, top_digit};
                    out_rem_next   = 4'd0;
                    out_last_next  = 1'b0;
                    pos_next       = pos_reg - 4'd1;
                    dcnt_next      = dcnt_reg - DCNT_W'(1);
                    ctrl.move      = 1'b1;
                end
            end
            ST_TAIL:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = DECODE_MODE_ADDR;
                    out_data_next  = restore_reg;
                    out_rem_next   = pos_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            restore_reg   <= RESTORE_DECODE_RST;
            minus_reg     <= MINUS_CODE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RESTORE_DECODE: restore_reg <= cfg_wdata;
                    CFG_MINUS_CODE:     minus_reg   <= cfg_wdata;
                    default:            restore_reg <= restore_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        pos_reg      <= pos_next;
        cnt_reg      <= cnt_next;
        dcnt_reg     <= dcnt_next;
        out_addr_reg <= out_addr_next;
        out_data_reg <= out_data_next;
        out_rem_reg  <= out_rem_next;
        out_last_reg <= out_last_next;
    end

    assign wr.valid              = out_valid_reg;
    assign wr.register_address   = out_addr_reg;
    assign wr.register_data      = out_data_reg;
    assign wr.remaining_position = out_rem_reg;
    assign wr.last_write         = out_last_reg;

endmodule

### design/sitb_checker.sv
// Port-level checker for the digit-register writer, bound to the top level.
// Uses sitb_pkg.
module sitb_checker
    import sitb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       num_valid,
    input logic       num_ready,
    input logic       wr_valid,
    input logic       wr_ready,
    input logic [3:0] wr_addr,
    input logic [7:0] wr_data,
    input logic [3:0] wr_rem,
    input logic       wr_last
);

    a_wr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !wr_ready |=> wr_valid && $stable(wr_addr) && $stable(wr_data)
                                  && $stable(wr_rem) && $stable(wr_last))
        else $error("stalled write changed");

    a_last_addr: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && wr_last |-> wr_addr == DECODE_MODE_ADDR)
        else $error("last write not to decode register");

    a_rem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !wr_last |-> wr_rem == 4'd0)
        else $error("remaining position set on non-last write");

    a_digit_addr: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && wr_addr != DECODE_MODE_ADDR |-> wr_addr >= 4'd1 && wr_addr <= 4'd8
                                                    && !wr_last)
        else $error("bad digit address");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        num_valid && num_ready |=> !num_ready)
        else $error("input taken while busy");

endmodule

bind signed_int_to_digit_writes_top sitb_checker u_sitb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .num_valid (num.valid),
    .num_ready (num.ready),
    .wr_valid  (wr.valid),
    .wr_ready  (wr.ready),
    .wr_addr   (wr.register_address),
    .wr_data   (wr.register_data),
    .wr_rem    (wr.remaining_position),
    .wr_last   (wr.last_write)
);

### test/signed_int_to_digit_writes_top_test.sv
// Testbench for signed_int_to_digit_writes_top: random and directed numbers with
// predicted register-write sequences, random idling on both channels.
// Depends on sitb_pkg, sitb_ifs and the top-level RTL.
`timescale 1ns / 1ps

module signed_int_to_digit_writes_top_test;
    import sitb_pkg::*;

    localparam int DIGIT_POSITIONS = 8;
    localparam int IDLE_PCT        = 11;
    localparam int PHASE_ITEMS     = 88;
    localparam int SETTLE_CYCLES   = 60;

    typedef struct {
        logic [31:0] value;
        logic [3:0]  start;
    } number_req_t;

    typedef struct {
        logic [3:0] addr;
        logic [7:0] data;
        logic [3:0] rem;
        logic       last;
    } digit_write_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [7:0] cfg_wdata;

    sitb_num_if num_ch ();
    sitb_wr_if  wr_ch ();

    signed_int_to_digit_writes_top #(.NUM_DIGITS(DIGIT_POSITIONS)) u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .num       (num_ch.sink),
        .wr        (wr_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    number_req_t  numbers_queued[$];
    digit_write_t writes_due[$];

    logic [7:0] restore_mode;
    logic [7:0] minus_byte;
    logic       num_taken;
    logic       steady;
    int         mismatches;
    int         numbers_done;
    int         writes_done;
    int         neg_numbers;
    int         cfg_settings;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("signed_int_to_digit_writes_top test failed");
        $finish;
    end

    // Expected write sequence for one number
    function automatic void predict_writes(logic [31:0] value, logic [3:0] start);
        logic [31:0] mag;
        logic [3:0]  digs[10];
        int          nd;
        int          pos;
        logic        neg;
        neg = value[31];
        mag = neg ? (32'd0 - value) : value;
        pos = (start > DIGIT_POSITIONS) ? DIGIT_POSITIONS : int'(start);
        nd  = 0;
        do
        begin
            digs[nd] = 4'(mag % 32'd10);
            nd++;
            mag = mag / 32'd10;
        end
        while (mag != 0 && nd < 10);
        writes_due.push_back('{DECODE_MODE_ADDR, DECODE_ALL, 4'd0, 1'b0});
        if (neg && pos > 0)
        begin
            writes_due.push_back('{4'(pos), minus_byte, 4'd0, 1'b0});
            pos--;
        end
        for (int d = nd - 1; d >= 0; d--)
        begin
            if (pos > 0)
            begin
                writes_due.push_back('{4'(pos), {4'd0, digs[d]}, 4'd0, 1'b0});
                pos--;
            end
        end
        writes_due.push_back('{DECODE_MODE_ADDR, restore_mode, 4'(pos), 1'b1});
    endfunction

    function automatic logic [31:0] pick_number();
        logic [31:0] v;
        logic [31:0] p;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = 32'($urandom_range(0, 999));
            2:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'd0;
                    default: v = 32'd1;
                endcase
            end
            3:
            begin
                p = 32'd1;
                repeat ($urandom_range(0, 9)) p = p * 32'd10;
                v = p - 32'($urandom_range(0, 1));
            end
            4: v = 32'($urandom_range(0, 99999));
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 1) && v != 32'h8000_0000)
            v = 32'd0 - v;
        return v;
    endfunction

    function automatic logic [3:0] pick_start();
        if ($urandom_range(0, 9) == 0)
            return 4'($urandom_range(9, 15));
        return 4'($urandom_range(0, DIGIT_POSITIONS));
    endfunction

    task automatic queue_number(logic [31:0] value, logic [3:0] start);
        numbers_queued.push_back('{value, start});
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            queue_number(pick_number(), pick_start());
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_RESTORE_DECODE)
            restore_mode = val;
        else
            minus_byte = val;
    endtask

    task automatic drain();
        while (numbers_queued.size() != 0 || num_ch.valid || writes_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(logic [7:0] restore_val, logic [7:0] minus_val);
        write_reg(CFG_RESTORE_DECODE, restore_val);
        write_reg(CFG_MINUS_CODE, minus_val);
        cfg_settings++;
    endtask

    // number channel driver
    always @(negedge clk)
    begin
        if (!rst_n)
            num_ch.valid <= 1'b0;
        else if (num_ch.valid && !num_taken)
            ;
        else if (numbers_queued.size() == 0 || (!steady && $urandom_range(0, 99) < IDLE_PCT))
            num_ch.valid <= 1'b0;
        else
        begin
            num_ch.valid          <= 1'b1;
            num_ch.number_value   <= numbers_queued[0].value;
            num_ch.start_position <= numbers_queued[0].start;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            wr_ch.ready <= 1'b0;
        else
            wr_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // input transfers feed the predictor
    always @(posedge clk)
    begin
        if (!rst_n)
            num_taken <= 1'b0;
        else
        begin
            num_taken <= num_ch.valid && num_ch.ready;
            if (num_ch.valid && num_ch.ready)
            begin
                void'(numbers_queued.pop_front());
                predict_writes(num_ch.number_value, num_ch.start_position);
                numbers_done++;
                if (num_ch.number_value[31])
                    neg_numbers++;
            end
        end
    end

    // output checker
    always @(posedge clk)
    begin
        digit_write_t want;
        if (rst_n && wr_ch.valid && wr_ch.ready)
        begin
            writes_done++;
            if (writes_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected write addr=%0d data=%02h rem=%0d last=%0b",
                             $realtime, wr_ch.register_address, wr_ch.register_data,
                             wr_ch.remaining_position, wr_ch.last_write);
            end
            else
            begin
                want = writes_due.pop_front();
                if (wr_ch.register_address !== want.addr
                    || wr_ch.register_data !== want.data
                    || wr_ch.remaining_position !== want.rem
                    || wr_ch.last_write !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: write mismatch exp addr=%0d data=%02h rem=%0d last=%0b",
                                  " got addr=%0d data=%02h rem=%0d last=%0b"},
                                 $realtime, want.addr, want.data, want.rem, want.last,
                                 wr_ch.register_address, wr_ch.register_data,
                                 wr_ch.remaining_position, wr_ch.last_write);
                end
            end
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = 1'b0;
        cfg_wdata           = 8'd0;
        num_ch.valid        = 1'b0;
        num_ch.number_value = 32'd0;
        num_ch.start_position = 4'd0;
        wr_ch.ready         = 1'b0;
        steady              = 1'b0;
        restore_mode        = RESTORE_DECODE_RST;
        minus_byte          = MINUS_CODE_RST;
        mismatches          = 0;
        numbers_done        = 0;
        writes_done         = 0;
        neg_numbers         = 0;
        cfg_settings        = 1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset config
        queue_number(32'd0, 4'd8);
        queue_number(32'hFFFF_FFFF, 4'd8);
        queue_number(32'h7FFF_FFFF, 4'd8);
        queue_number(32'h8000_0000, 4'd8);
        queue_number(32'h8000_0000, 4'd15);
        queue_number(32'd12345, 4'd0);
        queue_number(-32'sd5, 4'd0);
        queue_number(-32'sd5, 4'd1);
        queue_number(32'd7, 4'd1);
        queue_number(32'd99, 4'd9);
        queue_number(32'd123, 4'd3);
        queue_number(-32'sd123, 4'd3);
        queue_number(32'd1000000, 4'd4);
        queue_number(32'd5, 4'd15);
        queue_number(32'd0, 4'd0);
        queue_number(32'hAAAA_AAAA, 4'd10);
        queue_number(32'h5555_5555, 4'd5);
        queue_number(32'd99999999, 4'd8);
        queue_number(-32'sd9999999, 4'd8);
        queue_number(32'd100000000, 4'd8);
        queue_random(PHASE_ITEMS);
        drain();

        set_config(8'hFF, 8'h00);
        queue_random(PHASE_ITEMS / 2);
        drain();
        queue_random(PHASE_ITEMS / 2);
        drain();

        set_config(8'h00, 8'hFF);
        steady = 1'b1;
        queue_random(PHASE_ITEMS);
        drain();
        steady = 1'b0;

        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        queue_random(PHASE_ITEMS);
        drain();

        set_config(8'h0F, 8'h0A);
        queue_random(PHASE_ITEMS);
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        mismatches += writes_due.size();
        $display("Covered %0d numbers (%0d negative), %0d register writes, %0d config settings",
                 numbers_done, neg_numbers, writes_done, cfg_settings);
        $display("Failures: %0d", mismatches);
        if (mismatches == 0)
            $display("signed_int_to_digit_writes_top test passed");
        else
            $display("signed_int_to_digit_writes_top test failed");
        $finish;
    end

endmodule
